>>> rtl/elcsr_pkg.sv
package elcsr_pkg;

  localparam int MAX_NODES  = 65536;
  localparam int MAX_EDGES  = 1048576;

  localparam int NODE_W     = 16;
  localparam int NCOUNT_W   = 17;
  localparam int ECOUNT_W   = 21;
  localparam int INDEX_W    = 20;
  localparam int KIND_W     = 2;
  localparam int ERR_W      = 3;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 21;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NODE_COUNT     = 1'd0,
    CFG_EXPECTED_EDGES = 1'd1
  } cfg_idx_t;

  typedef enum logic {
    OP_EDGE = 1'b0,
    OP_END  = 1'b1
  } opcode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_FILL = 2'd0,
    KIND_COL  = 2'd1,
    KIND_DONE = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE     = 3'd0,
    ERR_NODE     = 3'd1,
    ERR_DECR     = 3'd2,
    ERR_TOO_MANY = 3'd3,
    ERR_TOO_FEW  = 3'd4
  } err_t;

  typedef struct packed {
    kind_t               kind;
    logic [INDEX_W-1:0]  first_index;
    logic [NODE_W-1:0]   last_row;
    logic [ECOUNT_W-1:0] value;
    err_t                error_code;
    logic                last;
  } res_t;

  // up to two result words produced by one accepted item
  typedef struct packed {
    logic [1:0] cnt;
    res_t       first;
    res_t       second;
  } push_t;

endpackage

>>> rtl/elcsr_in_if.sv
interface elcsr_in_if
  import elcsr_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [NODE_W-1:0] src_vertex;
  logic [NODE_W-1:0] dst_vertex;

  modport source (output valid, output opcode, output src_vertex, output dst_vertex,
                  input ready);
  modport sink   (input valid, input opcode, input src_vertex, input dst_vertex,
                  output ready);
endinterface

>>> rtl/elcsr_out_if.sv
interface elcsr_out_if
  import elcsr_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   result_kind;
  logic [INDEX_W-1:0]  first_index;
  logic [NODE_W-1:0]   last_row;
  logic [ECOUNT_W-1:0] value;
  logic [ERR_W-1:0]    error_code;
  logic                last;

  modport source (output valid, output result_kind, output first_index, output last_row,
                  output value, output error_code, output last, input ready);
  modport sink   (input valid, input result_kind, input first_index, input last_row,
                  input value, input error_code, input last, output ready);
endinterface

>>> rtl/elcsr_cfg_if.sv
interface elcsr_cfg_if
  import elcsr_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/elcsr_result_fifo.sv
module elcsr_result_fifo
  import elcsr_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push_i,
  input  logic  pop_i,
  output logic  room_o,
  output logic  head_valid_o,
  output res_t  head_o
);

  res_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [PTR_W-1:0] wr_ptr_p1;

  assign wr_ptr_p1    = wr_ptr_r + PTR_W'(1);
  assign room_o       = count_r <= CNT_W'(FIFO_DEPTH - 2);
  assign head_valid_o = count_r != '0;
  assign head_o       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push_i.cnt);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop_i);
    count_nxt  = count_r + CNT_W'(push_i.cnt) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk) begin
    if (push_i.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push_i.first;
    end
    if (push_i.cnt == 2'd2) begin
      mem_r[wr_ptr_p1] <= push_i.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(FIFO_DEPTH))
    else $error("result queue count above depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, count_r} + (CNT_W + 1)'(push_i.cnt)) <= (CNT_W + 1)'(FIFO_DEPTH))
    else $error("result queue pushed past depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> count_r != '0)
    else $error("result queue popped while empty");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0 && count_r != CNT_W'(FIFO_DEPTH)) |-> wr_ptr_r != rd_ptr_r)
    else $error("result queue pointers disagree with count");

endmodule

>>> rtl/edge_list_to_csr_builder_core.sv
// Edge list to CSR builder. Takes one word per cycle while its input is ready: an edge
// (source, destination), sorted by source, or an end-of-list marker. Each good edge yields
// a column write, preceded by a row offset fill whenever the source advances (the first
// edge's fill starts at row 0). An end word yields a finished or error word, or nothing
// when the run has already failed, and returns the block to its idle run state; after any
// error, edges are dropped silently until the next end word. Results are registered into a
// four-word result queue and leave at one word per cycle while the receiver is ready; the
// input is ready whenever that queue has room for two words, so items that cause a single
// result run at one per cycle while the output is not held, and items that cause a fill
// plus a column write are paced by the output port.
// Configure node_count and expected_edges only while no results are pending.
module edge_list_to_csr_builder_core
  import elcsr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  elcsr_in_if.sink   in_ch,
  elcsr_out_if.source out_ch,
  elcsr_cfg_if.sink  cfg_ch
);

  logic [NCOUNT_W-1:0] node_count_r;
  logic [ECOUNT_W-1:0] expected_edges_r;

  logic [NODE_W-1:0]   current_row_r, current_row_nxt;
  logic [ECOUNT_W-1:0] edges_seen_r, edges_seen_nxt;
  logic                started_r, started_nxt;
  logic                halted_r, halted_nxt;

  logic [NCOUNT_W-1:0] nodes;
  logic [ECOUNT_W-1:0] limit;
  err_t                edge_err;
  logic                in_acc;
  logic                need_fill;
  push_t               push;
  logic                room;
  logic                head_valid;
  res_t                head;
  logic                pop;

  // configuration port
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r     <= NCOUNT_W'(MAX_NODES);
      expected_edges_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_NODE_COUNT:     node_count_r     <= cfg_ch.data[NCOUNT_W-1:0];
        CFG_EXPECTED_EDGES: expected_edges_r <= cfg_ch.data[ECOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign nodes = (node_count_r > NCOUNT_W'(MAX_NODES)) ? NCOUNT_W'(MAX_NODES) : node_count_r;
  assign limit = (expected_edges_r > ECOUNT_W'(MAX_EDGES)) ?
                 ECOUNT_W'(MAX_EDGES) : expected_edges_r;

  assign in_ch.ready = room;
  assign in_acc      = in_ch.valid && room;

  always_comb begin
    if ({1'b0, in_ch.src_vertex} >= nodes || {1'b0, in_ch.dst_vertex} >= nodes) begin
      edge_err = ERR_NODE;
    end else if (in_ch.src_vertex < current_row_r) begin
      edge_err = ERR_DECR;
    end else if (edges_seen_r >= limit) begin
      edge_err = ERR_TOO_MANY;
    end else begin
      edge_err = ERR_NONE;
    end
  end

  assign need_fill = !started_r || (in_ch.src_vertex > current_row_r);

  always_comb begin
    push            = '0;
    current_row_nxt = current_row_r;
    edges_seen_nxt  = edges_seen_r;
    started_nxt     = started_r;
    halted_nxt      = halted_r;
    if (in_acc) begin
      if (opcode_t'(in_ch.opcode) == OP_END) begin
        if (!halted_r) begin
          push.cnt               = 2'd1;
          push.first.value       = edges_seen_r;
          push.first.last        = 1'b1;
          if (edges_seen_r != limit) begin
            push.first.kind       = KIND_ERR;
            push.first.error_code = ERR_TOO_FEW;
          end else begin
            push.first.kind       = KIND_DONE;
          end
        end
        current_row_nxt = '0;
        edges_seen_nxt  = '0;
        started_nxt     = 1'b0;
        halted_nxt      = 1'b0;
      end else if (!halted_r) begin
        if (edge_err != ERR_NONE) begin
          // report and halt; no fill or column write for this edge
          halted_nxt             = 1'b1;
          push.cnt               = 2'd1;
          push.first.kind        = KIND_ERR;
          push.first.value       = edges_seen_r;
          push.first.error_code  = edge_err;
          push.first.last        = 1'b1;
        end else begin
          if (need_fill) begin
            push.cnt                = 2'd2;
            push.first.kind         = KIND_FILL;
            push.first.first_index  = started_r ?
                                      ({{(INDEX_W-NODE_W){1'b0}}, current_row_r} + INDEX_W'(1)) :
                                      '0;
            push.first.last_row     = in_ch.src_vertex;
            push.first.value        = edges_seen_r;
            push.second.kind        = KIND_COL;
            push.second.first_index = edges_seen_r[INDEX_W-1:0];
            push.second.value       = {{(ECOUNT_W-NODE_W){1'b0}}, in_ch.dst_vertex};
            push.second.last        = 1'b1;
          end else begin
            push.cnt               = 2'd1;
            push.first.kind        = KIND_COL;
            push.first.first_index = edges_seen_r[INDEX_W-1:0];
            push.first.value       = {{(ECOUNT_W-NODE_W){1'b0}}, in_ch.dst_vertex};
            push.first.last        = 1'b1;
          end
          edges_seen_nxt  = edges_seen_r + ECOUNT_W'(1);
          current_row_nxt = in_ch.src_vertex;
          started_nxt     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      current_row_r <= '0;
      edges_seen_r  <= '0;
      started_r     <= 1'b0;
      halted_r      <= 1'b0;
    end else begin
      current_row_r <= current_row_nxt;
      edges_seen_r  <= edges_seen_nxt;
      started_r     <= started_nxt;
      halted_r      <= halted_nxt;
    end
  end

  elcsr_result_fifo u_fifo (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_i       (push),
    .pop_i        (pop),
    .room_o       (room),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  assign pop                = head_valid && out_ch.ready;
  assign out_ch.valid       = head_valid;
  assign out_ch.result_kind = head.kind;
  assign out_ch.first_index = head.first_index;
  assign out_ch.last_row    = head.last_row;
  assign out_ch.value       = head.value;
  assign out_ch.error_code  = head.error_code;
  assign out_ch.last        = head.last;

  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && opcode_t'(in_ch.opcode) == OP_EDGE && !halted_r && edge_err != ERR_NONE)
    |=> halted_r)
    else $error("edge error did not halt the run");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && opcode_t'(in_ch.opcode) == OP_END)
    |=> (!started_r && !halted_r && edges_seen_r == '0 && current_row_r == '0))
    else $error("end word did not restore the idle run state");

  a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (halted_r && opcode_t'(in_ch.opcode) == OP_EDGE) |-> push.cnt == 2'd0)
    else $error("edge produced a result while halted");

  a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && opcode_t'(in_ch.opcode) == OP_EDGE && !halted_r && edge_err == ERR_NONE)
    |=> edges_seen_r == $past(edges_seen_r) + ECOUNT_W'(1))
    else $error("edge count did not advance on a good edge");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import elcsr_pkg::*;

  localparam int RANDOM_ITEMS = 1900;
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_CYCLES  = 120;

  logic clk = 1'b0;
  logic rst_n;

  elcsr_in_if  in_if ();
  elcsr_out_if out_if ();
  elcsr_cfg_if cfg_if ();

  edge_list_to_csr_builder_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the block's registers and run state
  logic [NCOUNT_W-1:0] cfg_nodes;
  logic [ECOUNT_W-1:0] cfg_edges;
  logic [NODE_W-1:0]   row_now;
  logic [ECOUNT_W-1:0] edge_cnt;
  bit                  seen_any;
  bit                  in_error;

  res_t pending_csr_words[$];

  bit idle_on;
  bit stall_on;
  bit hold_req;
  int mismatches;
  int sent_items;

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void clear_run_state();
    row_now  = '0;
    edge_cnt = '0;
    seen_any = 1'b0;
    in_error = 1'b0;
  endfunction

  function automatic void push_word(kind_t k, logic [INDEX_W-1:0] fi, logic [NODE_W-1:0] lr,
                                    logic [ECOUNT_W-1:0] v, err_t e, logic lst);
    res_t w;
    w.kind        = k;
    w.first_index = fi;
    w.last_row    = lr;
    w.value       = v;
    w.error_code  = e;
    w.last        = lst;
    pending_csr_words.push_back(w);
  endfunction

  // work out the CSR words one accepted item causes
  function automatic void build_csr_words(opcode_t op, logic [NODE_W-1:0] src,
                                          logic [NODE_W-1:0] dst);
    int unsigned nodes;
    int unsigned limit;
    err_t        e;
    nodes = (cfg_nodes < MAX_NODES) ? cfg_nodes : MAX_NODES;
    limit = (cfg_edges < MAX_EDGES) ? cfg_edges : MAX_EDGES;
    if (op == OP_END) begin
      if (!in_error) begin
        if (edge_cnt != limit) push_word(KIND_ERR, '0, '0, edge_cnt, ERR_TOO_FEW, 1'b1);
        else push_word(KIND_DONE, '0, '0, edge_cnt, ERR_NONE, 1'b1);
      end
      clear_run_state();
      return;
    end
    if (in_error) return;
    e = ERR_NONE;
    if (src >= nodes || dst >= nodes) e = ERR_NODE;
    else if (src < row_now) e = ERR_DECR;
    else if (edge_cnt >= limit) e = ERR_TOO_MANY;
    if (e != ERR_NONE) begin
      in_error = 1'b1;
      push_word(KIND_ERR, '0, '0, edge_cnt, e, 1'b1);
      return;
    end
    if (!seen_any) begin
      push_word(KIND_FILL, '0, src, edge_cnt, ERR_NONE, 1'b0);
    end else if (src > row_now) begin
      push_word(KIND_FILL, INDEX_W'(row_now) + 1'b1, src, edge_cnt, ERR_NONE, 1'b0);
    end
    push_word(KIND_COL, edge_cnt[INDEX_W-1:0], '0, ECOUNT_W'(dst), ERR_NONE, 1'b1);
    edge_cnt = edge_cnt + 1'b1;
    row_now  = src;
    seen_any = 1'b1;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("%0t: csr word mismatch on %s: got 0x%0h, expected 0x%0h",
             $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_word();
    res_t want;
    if (pending_csr_words.size() == 0) begin
      report_mismatch("kind of word with nothing pending", 64'(out_if.result_kind), 64'(0));
      return;
    end
    want = pending_csr_words.pop_front();
    if (out_if.result_kind !== want.kind)
      report_mismatch("result_kind", 64'(out_if.result_kind), 64'(want.kind));
    if (out_if.first_index !== want.first_index)
      report_mismatch("first_index", 64'(out_if.first_index), 64'(want.first_index));
    if (out_if.last_row !== want.last_row)
      report_mismatch("last_row", 64'(out_if.last_row), 64'(want.last_row));
    if (out_if.value !== want.value)
      report_mismatch("value", 64'(out_if.value), 64'(want.value));
    if (out_if.error_code !== want.error_code)
      report_mismatch("error_code", 64'(out_if.error_code), 64'(want.error_code));
    if (out_if.last !== want.last)
      report_mismatch("last", 64'(out_if.last), 64'(want.last));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) check_word();
  end

  // result receiver: random stalls, plus one long hold on request
  initial begin : result_sink
    int stall;
    forever begin
      @(posedge clk);
      stall = 0;
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
        stall = rand_gap();
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
    end
  end

  // call at a rising edge; returns at the edge the word is taken, valid left high
  task automatic send_word(opcode_t op, logic [NODE_W-1:0] src, logic [NODE_W-1:0] dst);
    int gap;
    gap = idle_on ? rand_gap() : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.opcode     <= op;
    in_if.src_vertex <= src;
    in_if.dst_vertex <= dst;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    build_csr_words(op, src, dst);
    sent_items++;
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_csr_words.size() != 0) @(posedge clk);
    // dropped items leave no word behind; give them time to clear the pipe
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_word(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      CFG_NODE_COUNT:     cfg_nodes = d[NCOUNT_W-1:0];
      CFG_EXPECTED_EDGES: cfg_edges = d;
      default: ;
    endcase
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] nodes, logic [CFG_DATA_W-1:0] edges);
    wait_idle();
    cfg_word(CFG_NODE_COUNT, nodes);
    cfg_word(CFG_EXPECTED_EDGES, edges);
    cfg_if.valid <= 1'b0;
  endtask

  // reset registers: no edges allowed, so the first edge overflows
  task automatic test_reset_values();
    send_word(OP_EDGE, 16'd0, 16'd0);
    send_word(OP_EDGE, 16'hFFFF, 16'hFFFF);
    send_word(OP_END, 16'd0, 16'd0);
    send_word(OP_END, 16'hFFFF, 16'h0);
  endtask

  task automatic test_row_fills();
    configure(21'd16, 21'd5);
    send_word(OP_EDGE, 16'd2, 16'd3);
    send_word(OP_EDGE, 16'd2, 16'd15);
    send_word(OP_EDGE, 16'd5, 16'd0);
    send_word(OP_END, 16'd0, 16'd0);
  endtask

  task automatic test_error_kinds();
    configure(21'd16, 21'd3);
    send_word(OP_EDGE, 16'd16, 16'd0);
    send_word(OP_END, 16'd0, 16'd0);
    send_word(OP_EDGE, 16'd0, 16'd16);
    send_word(OP_END, 16'd0, 16'd0);
    send_word(OP_EDGE, 16'd4, 16'd1);
    send_word(OP_EDGE, 16'd3, 16'd1);
    send_word(OP_END, 16'd0, 16'd0);
    send_word(OP_EDGE, 16'd0, 16'd0);
    send_word(OP_EDGE, 16'd0, 16'd1);
    send_word(OP_EDGE, 16'd15, 16'd15);
    send_word(OP_EDGE, 16'd15, 16'd2);
    send_word(OP_END, 16'd0, 16'd0);
    send_word(OP_EDGE, 16'd0, 16'd0);
    send_word(OP_EDGE, 16'd3, 16'd3);
    send_word(OP_EDGE, 16'd3, 16'd4);
    send_word(OP_END, 16'd0, 16'd0);
  endtask

  task automatic test_register_extremes();
    configure(21'h1FFFF, 21'h1FFFFF);
    send_word(OP_EDGE, 16'hFFFF, 16'hFFFF);
    send_word(OP_EDGE, 16'hFFFF, 16'h0);
    send_word(OP_END, 16'd0, 16'd0);
    configure(21'd0, 21'd1);
    send_word(OP_EDGE, 16'd0, 16'd0);
    send_word(OP_END, 16'd0, 16'd0);
    configure(21'd1, 21'd1);
    send_word(OP_EDGE, 16'd0, 16'd0);
    send_word(OP_END, 16'd0, 16'd0);
  endtask

  // hold the result side while edges keep coming so the result queue fills up
  task automatic test_output_backpressure();
    configure(21'd1024, 21'd40);
    idle_on  = 1'b0;
    stall_on = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) send_word(OP_EDGE, 16'(i * 3), 16'(i));
    send_word(OP_END, 16'd0, 16'd0);
  endtask

  task automatic test_random_lists();
    int unsigned         nodes_cfg;
    int unsigned         eff;
    int unsigned         top;
    int unsigned         len;
    int unsigned         pick;
    int unsigned         step;
    logic [ECOUNT_W-1:0] edges_cfg;
    logic [NODE_W-1:0]   src;
    logic [NODE_W-1:0]   dst;
    while (sent_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) nodes_cfg = 0;
      else if (pick == 1) nodes_cfg = 1;
      else if (pick <= 3) nodes_cfg = $urandom_range(0, 21'h1FFFFF);
      else if (pick <= 9) nodes_cfg = $urandom_range(2, 64);
      else if (pick <= 14) nodes_cfg = MAX_NODES;
      else nodes_cfg = $urandom_range(65, 4096);
      eff = nodes_cfg & 32'h1FFFF;
      if (eff > MAX_NODES) eff = MAX_NODES;
      top = (eff > 0) ? eff - 1 : 0;

      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
      pick = $urandom_range(0, 19);
      if (pick < 14) edges_cfg = ECOUNT_W'(len);
      else if (pick < 16) edges_cfg = ECOUNT_W'(len + 1);
      else if (pick < 18) edges_cfg = ECOUNT_W'((len > 0) ? len - 1 : 0);
      else if (pick == 18) edges_cfg = '1;
      else edges_cfg = ECOUNT_W'($urandom);
      configure(nodes_cfg[CFG_DATA_W-1:0], edges_cfg);

      idle_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      src = $urandom_range(0, 1) ? '0 : NODE_W'($urandom_range(0, top));
      for (int i = 0; i < len; i++) begin
        dst  = NODE_W'($urandom_range(0, top));
        pick = $urandom_range(0, 11);
        if (eff == 0 || pick == 0) begin
          send_word(OP_EDGE, NODE_W'($urandom), NODE_W'($urandom));
        end else if (pick == 1) begin
          // break the list: step back, push a node past the end, or end early
          step = $urandom_range(0, 2);
          if (step == 0) send_word(OP_EDGE, NODE_W'($urandom_range(0, src)), dst);
          else if (step == 1 && eff < MAX_NODES)
            send_word(OP_EDGE, src, NODE_W'($urandom_range(eff, 16'hFFFF)));
          else send_word(OP_END, NODE_W'($urandom), NODE_W'($urandom));
        end else begin
          step = $urandom_range(0, 3);
          if (step < 2) step = 0;
          else if (step == 2) step = 1;
          else step = $urandom_range(2, 64);
          if (src + step > top) src = NODE_W'(top);
          else src = NODE_W'(src + step);
          send_word(OP_EDGE, src, dst);
        end
      end
      send_word(OP_END, NODE_W'($urandom), NODE_W'($urandom));
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.opcode     = OP_EDGE;
    in_if.src_vertex = '0;
    in_if.dst_vertex = '0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = CFG_NODE_COUNT;
    cfg_if.data      = '0;
    idle_on          = 1'b0;
    stall_on         = 1'b0;
    hold_req         = 1'b0;
    mismatches       = 0;
    sent_items       = 0;
    cfg_nodes        = NCOUNT_W'(MAX_NODES);
    cfg_edges        = '0;
    clear_run_state();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    idle_on  = 1'b1;
    stall_on = 1'b1;
    test_row_fills();
    test_error_kinds();
    test_register_extremes();
    test_output_backpressure();
    test_random_lists();

    wait_idle();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

endmodule
